@@ design/baro_pkg.sv @@
// Shared types, register indexes, status codes and sizes for the barometer compensation block
`timescale 1ns / 1ps

package baro_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_T1    = 3'd0;
	localparam logic [2:0] REG_T2_T3 = 3'd1;
	localparam logic [2:0] REG_P1    = 3'd2;
	localparam logic [2:0] REG_P2_P3 = 3'd3;
	localparam logic [2:0] REG_P4_P5 = 3'd4;
	localparam logic [2:0] REG_P6_P7 = 3'd5;
	localparam logic [2:0] REG_P8_P9 = 3'd6;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_T     = 3'd1;
	localparam logic [2:0] ST_FINE_ZERO = 3'd2;
	localparam logic [2:0] ST_BAD_P     = 3'd3;
	localparam logic [2:0] ST_DIV_ZERO  = 3'd4;

	localparam logic [19:0] RAW_ONES = 20'hFFFFF;

	// queue between front and back
	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;

	// back pipeline: eight arithmetic stages, one stage per quotient bit, six after
	localparam int DIV_BITS    = 64;
	localparam int BACK_STAGES = 8 + DIV_BITS + 6;
	localparam int DIV_ZCHK    = 6;

	// calibration words, split out of the packed registers
	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] temp;
		logic signed [31:0] fine;
		logic [19:0]        adc_p;
	} q_entry_t;

endpackage

@@ design/baro_front.sv @@
// Front end: temperature compensation and request classification
`timescale 1ns / 1ps

module baro_front import baro_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cal_t        cal,
	input  logic        acc,
	input  logic [19:0] raw_temp,
	input  logic [19:0] raw_press,
	output logic        push,
	output q_entry_t    push_data
);

	logic [3:0] vf_q;

	logic signed [31:0] a0_c, pa_c, d_c, dd_c;
	logic signed [31:0] pa_s1, dd_s1;
	logic [19:0]        rawp_s1, rawp_s2, rawp_s3;
	logic               badt_s1, badt_s2, badt_s3;
	logic               badp_s1, badp_s2, badp_s3;

	logic signed [31:0] dda_c, b_c;
	logic signed [31:0] a_s2, b_s2;
	logic signed [31:0] fine_s3;
	logic signed [31:0] fine5_c, temp_c;
	q_entry_t           ent_s4;

	// valid line, front never stalls (credits guarantee queue room)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_q <= '0;
		end else begin
			vf_q <= {vf_q[2:0], acc};
		end
	end

	// stage 1: offsets and first products
	always_comb begin
		a0_c = $signed({15'b0, raw_temp[19:3]}) - $signed({15'b0, cal.t1, 1'b0});
		d_c  = $signed({16'b0, raw_temp[19:4]}) - $signed({16'b0, cal.t1});
		pa_c = a0_c * $signed(cal.t2);
		dd_c = d_c * d_c;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pa_s1   <= pa_c;
			dd_s1   <= dd_c;
			rawp_s1 <= raw_press;
			badt_s1 <= (raw_temp == '0) || (raw_temp == RAW_ONES);
			badp_s1 <= (raw_press == '0) || (raw_press == RAW_ONES);
		end
	end

	// stage 2: scale and second product
	assign dda_c = dd_s1 >>> 12;
	assign b_c   = dda_c * $signed(cal.t3);

	always_ff @(posedge clk) begin
		a_s2    <= pa_s1 >>> 11;
		b_s2    <= b_c;
		rawp_s2 <= rawp_s1;
		badt_s2 <= badt_s1;
		badp_s2 <= badp_s1;
	end

	// stage 3: fine temperature
	always_ff @(posedge clk) begin
		fine_s3 <= a_s2 + (b_s2 >>> 14);
		rawp_s3 <= rawp_s2;
		badt_s3 <= badt_s2;
		badp_s3 <= badp_s2;
	end

	// stage 4: temperature in hundredths and status
	assign fine5_c = (fine_s3 <<< 2) + fine_s3;
	assign temp_c  = (fine5_c + 32'sd128) >>> 8;

	always_ff @(posedge clk) begin
		ent_s4.fine  <= fine_s3;
		ent_s4.adc_p <= rawp_s3;
		ent_s4.temp  <= badt_s3 ? 32'sd0 : temp_c;
		if (badt_s3) begin
			ent_s4.status <= ST_BAD_T;
		end else if (fine_s3 == 32'sd0) begin
			ent_s4.status <= ST_FINE_ZERO;
		end else if (badp_s3) begin
			ent_s4.status <= ST_BAD_P;
		end else begin
			ent_s4.status <= ST_OK;
		end
	end

	assign push      = vf_q[3];
	assign push_data = ent_s4;

endmodule

@@ design/baro_fifo.sv @@
// Short request queue between the front and back pipelines
`timescale 1ns / 1ps

module baro_fifo import baro_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	input  logic     pop,
	output logic     head_valid,
	output q_entry_t head
);

	q_entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

endmodule

@@ design/baro_back.sv @@
// Back end: 64-bit pressure compensation with a pipelined restoring divider
`timescale 1ns / 1ps

module baro_back import baro_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cal_t               cal,
	input  logic               hd_valid,
	input  q_entry_t           hd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temp_centi_c,
	output logic [31:0]        pressure_pa,
	output logic [2:0]         status
);

	logic [BACK_STAGES-1:0] vld_q;
	logic                   adv;

	// status and temperature ride along every stage
	logic [2:0]         st_q [BACK_STAGES];
	logic signed [31:0] tp_q [BACK_STAGES];

	logic signed [32:0] v_c;
	logic signed [65:0] sq_c;
	logic signed [48:0] m5_c, m2_c;

	logic [63:0]        sq_s1;
	logic signed [48:0] m5_s1, m2_s1, m5_s2, m2_s2, m5_s3, m2_s3;
	logic [20:0]        pp_s1, pp_s2, pp_s3, pp_s4;

	logic signed [48:0] lo6_c, lo3_c, lo6_s2, lo3_s2;
	logic signed [31:0] hi6_c, hi3_c, hi6_s2, hi3_s2;

	logic [63:0]        c6_s3;
	logic signed [63:0] c3_s3, c3a_c;

	logic [63:0]        v2_s4, w0_s4;
	logic [63:0]        n0_s5;
	logic [47:0]        wlo_s5;
	logic [31:0]        whi_s5;
	logic [63:0]        w_s6;
	logic [43:0]        nlo_s6;
	logic [31:0]        nhi_s6;
	logic [63:0]        n_s7;
	logic signed [30:0] d_s7;

	// divider lines, index is the number of quotient bits done
	logic [30:0] rem_q [DIV_BITS];
	logic [63:0] nq_q  [DIV_BITS+1];
	logic [30:0] dv_q  [DIV_BITS];
	logic        neg_q [DIV_BITS+1];
	logic [31:0] tr_c  [DIV_BITS];
	logic        ge_c  [DIV_BITS];

	logic signed [63:0] q_s9, q_s10, q_s11, q_s12;
	logic signed [63:0] r_c;
	logic [63:0]        rrlo_s10;
	logic [31:0]        rrx_s10;
	logic signed [48:0] blo_c, blo_s10;
	logic signed [31:0] bhi_c, bhi_s10;
	logic [63:0]        rr_s11;
	logic signed [63:0] bp_c, bb_s11, bb_s12;
	logic signed [48:0] alo_c, alo_s12;
	logic signed [31:0] ahi_c, ahi_s12;
	logic signed [63:0] ap_c, aa_c, s_s13;
	logic signed [63:0] s8_c, p7s_c, p_c;
	logic [31:0]        press_s14;

	// whole back pipeline moves when the output register is free or taken
	assign adv = !vld_q[BACK_STAGES-1] || !out_stall;
	assign pop = adv && hd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[BACK_STAGES-2:0], hd_valid};
		end
	end

	// carried status and temperature; status may turn into zero divisor
	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= hd.status;
			tp_q[0] <= hd.temp;
			for (int i = 1; i < BACK_STAGES; i++) begin
				if (i == DIV_ZCHK && st_q[i-1] == ST_OK && w_s6[63:33] == '0) begin
					st_q[i] <= ST_DIV_ZERO;
				end else begin
					st_q[i] <= st_q[i-1];
				end
				tp_q[i] <= tp_q[i-1];
			end
		end
	end

	// stage 1: offset fine temperature and its products
	assign v_c = $signed({hd.fine[31], hd.fine}) - 33'sd128000;
	always_comb begin
		sq_c = v_c * v_c;
		m5_c = v_c * $signed(cal.p5);
		m2_c = v_c * $signed(cal.p2);
	end

	// stage 2: partial products against p6 and p3
	always_comb begin
		lo6_c = $signed({1'b0, sq_s1[31:0]}) * $signed(cal.p6);
		hi6_c = $signed(sq_s1[63:32]) * $signed(cal.p6);
		lo3_c = $signed({1'b0, sq_s1[31:0]}) * $signed(cal.p3);
		hi3_c = $signed(sq_s1[63:32]) * $signed(cal.p3);
	end

	assign c3a_c = c3_s3 >>> 8;

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			sq_s1 <= sq_c[63:0];
			m5_s1 <= m5_c;
			m2_s1 <= m2_c;
			pp_s1 <= 21'd1048576 - {1'b0, hd.adc_p};
			// stage 2
			lo6_s2 <= lo6_c;
			hi6_s2 <= hi6_c;
			lo3_s2 <= lo3_c;
			hi3_s2 <= hi3_c;
			m5_s2  <= m5_s1;
			m2_s2  <= m2_s1;
			pp_s2  <= pp_s1;
			// stage 3: recombine partials
			c6_s3 <= {{15{lo6_s2[48]}}, lo6_s2} + {hi6_s2, 32'b0};
			c3_s3 <= $signed({{15{lo3_s2[48]}}, lo3_s2} + {hi3_s2, 32'b0});
			m5_s3 <= m5_s2;
			m2_s3 <= m2_s2;
			pp_s3 <= pp_s2;
			// stage 4: var2 and shifted var1
			v2_s4 <= c6_s3 + ({{15{m5_s3[48]}}, m5_s3} << 17)
				+ ({{48{cal.p4[15]}}, cal.p4} << 35);
			w0_s4 <= 64'h0000_8000_0000_0000 + c3a_c
				+ ({{15{m2_s3[48]}}, m2_s3} << 12);
			pp_s4 <= pp_s3;
			// stage 5: numerator base, divisor partials
			n0_s5  <= {12'b0, pp_s4, 31'b0} - v2_s4;
			wlo_s5 <= w0_s4[31:0] * cal.p1;
			whi_s5 <= w0_s4[63:32] * {16'b0, cal.p1};
			// stage 6: divisor product, numerator partials
			w_s6   <= {16'b0, wlo_s5} + {whi_s5, 32'b0};
			nlo_s6 <= n0_s5[31:0] * 12'd3125;
			nhi_s6 <= n0_s5[63:32] * 32'd3125;
			// stage 7: numerator and divisor
			n_s7 <= {20'b0, nlo_s6} + {nhi_s6, 32'b0};
			d_s7 <= $signed(w_s6[63:33]);
			// stage 8: magnitudes and quotient sign
			rem_q[0] <= '0;
			nq_q[0]  <= n_s7[63] ? (64'd0 - n_s7) : n_s7;
			dv_q[0]  <= d_s7[30] ? (31'd0 - d_s7) : d_s7;
			neg_q[0] <= n_s7[63] ^ d_s7[30];
		end
	end

	// restoring division, one quotient bit per stage
	always_comb begin
		for (int k = 0; k < DIV_BITS; k++) begin
			tr_c[k] = {rem_q[k], nq_q[k][63]};
			ge_c[k] = tr_c[k] >= {1'b0, dv_q[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_BITS - 1; k++) begin
				rem_q[k+1] <= ge_c[k] ? 31'(tr_c[k] - {1'b0, dv_q[k]}) : tr_c[k][30:0];
				dv_q[k+1]  <= dv_q[k];
			end
			for (int k = 0; k < DIV_BITS; k++) begin
				nq_q[k+1]  <= {nq_q[k][62:0], ge_c[k]};
				neg_q[k+1] <= neg_q[k];
			end
		end
	end

	// correction terms
	assign r_c = q_s9 >>> 13;
	always_comb begin
		blo_c = $signed({1'b0, q_s9[31:0]}) * $signed(cal.p8);
		bhi_c = $signed(q_s9[63:32]) * $signed(cal.p8);
		bp_c  = $signed({{15{blo_s10[48]}}, blo_s10} + {bhi_s10, 32'b0});
		alo_c = $signed({1'b0, rr_s11[31:0]}) * $signed(cal.p9);
		ahi_c = $signed(rr_s11[63:32]) * $signed(cal.p9);
		ap_c  = $signed({{15{alo_s12[48]}}, alo_s12} + {ahi_s12, 32'b0});
		aa_c  = ap_c >>> 25;
		s8_c  = s_s13 >>> 8;
		p7s_c = $signed({{48{cal.p7[15]}}, cal.p7}) <<< 4;
		p_c   = s8_c + p7s_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// signed quotient
			q_s9 <= $signed(neg_q[DIV_BITS] ? (64'd0 - nq_q[DIV_BITS]) : nq_q[DIV_BITS]);
			// square of the scaled quotient, p8 partials
			rrlo_s10 <= r_c[31:0] * r_c[31:0];
			rrx_s10  <= r_c[31:0] * r_c[63:32];
			blo_s10  <= blo_c;
			bhi_s10  <= bhi_c;
			q_s10    <= q_s9;
			// recombine
			rr_s11 <= rrlo_s10 + {rrx_s10[30:0], 33'b0};
			bb_s11 <= bp_c >>> 19;
			q_s11  <= q_s10;
			// p9 partials
			alo_s12 <= alo_c;
			ahi_s12 <= ahi_c;
			bb_s12  <= bb_s11;
			q_s12   <= q_s11;
			// sum
			s_s13 <= q_s12 + aa_c + bb_s12;
			// final offset and scale, status gates the result
			press_s14 <= (st_q[BACK_STAGES-2] == ST_OK) ? p_c[39:8] : 32'd0;
		end
	end

	assign out_valid    = vld_q[BACK_STAGES-1];
	assign temp_centi_c = tp_q[BACK_STAGES-1];
	assign status       = st_q[BACK_STAGES-1];
	assign pressure_pa  = press_s14;

endmodule

@@ design/baro_temp_pressure_compensation.sv @@
// Top level of the barometer temperature and pressure compensation block
`timescale 1ns / 1ps

// Takes one request (raw temperature and raw pressure, 20 bits each) per clock while in_stall
// is low and returns one result per request, in order: temperature in 0.01 degC, pressure in
// Pa and a status code. Sustained rate is one request per cycle while out_stall is low. Each
// request passes the temperature front end, the 8-entry queue and the pressure back end, most
// of which is the 64-stage divider that produces one quotient bit per stage. Input stall
// rises when 8 requests are held between input and back end. Calibration writes are always
// ready and must only be issued while the block is empty.

module baro_temp_pressure_compensation import baro_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_temp,
	input  logic [19:0]        raw_press,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temp_centi_c,
	output logic [31:0]        pressure_pa,
	output logic [2:0]         status
);

	logic [15:0] t1_q, p1_q;
	logic [31:0] t23_q, p23_q, p45_q, p67_q, p89_q;
	cal_t        cal;

	logic              acc, push, pop, hd_valid;
	q_entry_t          push_data, hd;
	logic [QCNT_W-1:0] cred_q;

	// calibration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t23_q <= '0;
			p1_q  <= '0;
			p23_q <= '0;
			p45_q <= '0;
			p67_q <= '0;
			p89_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_T1:    t1_q  <= cfg_data[15:0];
				REG_T2_T3: t23_q <= cfg_data;
				REG_P1:    p1_q  <= cfg_data[15:0];
				REG_P2_P3: p23_q <= cfg_data;
				REG_P4_P5: p45_q <= cfg_data;
				REG_P6_P7: p67_q <= cfg_data;
				REG_P8_P9: p89_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cal.t1 = t1_q;
		cal.t2 = $signed(t23_q[15:0]);
		cal.t3 = $signed(t23_q[31:16]);
		cal.p1 = p1_q;
		cal.p2 = $signed(p23_q[15:0]);
		cal.p3 = $signed(p23_q[31:16]);
		cal.p4 = $signed(p45_q[15:0]);
		cal.p5 = $signed(p45_q[31:16]);
		cal.p6 = $signed(p67_q[15:0]);
		cal.p7 = $signed(p67_q[31:16]);
		cal.p8 = $signed(p89_q[15:0]);
		cal.p9 = $signed(p89_q[31:16]);
	end

	// credits: requests accepted but not yet taken from the queue
	assign in_stall = (cred_q == QCNT_W'(QDEPTH));
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			cred_q <= cred_q + QCNT_W'(acc) - QCNT_W'(pop);
		end
	end

	baro_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal),
		.acc       (acc),
		.raw_temp  (raw_temp),
		.raw_press (raw_press),
		.push      (push),
		.push_data (push_data)
	);

	baro_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (hd_valid),
		.head       (hd)
	);

	baro_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cal          (cal),
		.hd_valid     (hd_valid),
		.hd           (hd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.temp_centi_c (temp_centi_c),
		.pressure_pa  (pressure_pa),
		.status       (status)
	);

endmodule
